// ----- hw/rtl/sptk_pkg.sv -----
// Shared types and constants for the tick to square-root price engine.
`default_nettype none
package sptk_pkg;

   localparam int unsigned TICK_W      = 21;
   localparam int unsigned MAG_W       = 20;
   localparam int unsigned RATIO_W     = 129;
   localparam int unsigned QUOT_W      = 256;
   localparam int unsigned PRICE_W     = 160;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             inv;
      logic             oor;
   } tick_class_type;

   typedef struct packed {
      logic               vld;
      logic               inv;
      logic               oor;
      logic [MAG_W-1:0]   mag;
      logic [RATIO_W-1:0] r;
   } mul_beat_type;

   typedef struct packed {
      logic               vld;
      logic               inv;
      logic               oor;
      logic [RATIO_W-1:0] r;
      logic [RATIO_W-1:0] rem;
      logic [QUOT_W-1:0]  q;
   } div_beat_type;

   function automatic logic [127:0] bit_mult(input logic [4:0] k);
      logic [127:0] c;
      case (k)
         5'd0:    c = 128'hfffcb933bd6fad37aa2d162d1a594001;
         5'd1:    c = 128'hfff97272373d413259a46990580e213a;
         5'd2:    c = 128'hfff2e50f5f656932ef12357cf3c7fdcc;
         5'd3:    c = 128'hffe5caca7e10e4e61c3624eaa0941cd0;
         5'd4:    c = 128'hffcb9843d60f6159c9db58835c926644;
         5'd5:    c = 128'hff973b41fa98c081472e6896dfb254c0;
         5'd6:    c = 128'hff2ea16466c96a3843ec78b326b52861;
         5'd7:    c = 128'hfe5dee046a99a2a811c461f1969c3053;
         5'd8:    c = 128'hfcbe86c7900a88aedcffc83b479aa3a4;
         5'd9:    c = 128'hf987a7253ac413176f2b074cf7815e54;
         5'd10:   c = 128'hf3392b0822b70005940c7a398e4b70f3;
         5'd11:   c = 128'he7159475a2c29b7443b29c7fa6e889d9;
         5'd12:   c = 128'hd097f3bdfd2022b8845ad8f792aa5825;
         5'd13:   c = 128'ha9f746462d870fdf8a65dc1f90e061e5;
         5'd14:   c = 128'h70d869a156d2a1b890bb3df62baf32f7;
         5'd15:   c = 128'h31be135f97d08fd981231505542fcfa6;
         5'd16:   c = 128'h09aa508b5b7a84e1c677de54f3e99bc9;
         5'd17:   c = 128'h005d6af8dedb81196699c329225ee604;
         5'd18:   c = 128'h00002216e584f5fa1ea926041bedfe98;
         5'd19:   c = 128'h00000000048a170391f7dc42444e8fa2;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sptk_front.sv -----
// Input side: takes tick beats and classifies them into magnitude, direction and range.
`default_nettype none
module sptk_front import sptk_pkg::*; #(
   parameter int unsigned TICK_LIMIT = 887272
) (
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [23:0]    req_tdata,   // [20:0] tick
   input  wire logic           q_full,
   output logic                q_push,
   output tick_class_type      q_entry
);

   logic [TICK_W-1:0] tick;
   logic [TICK_W-1:0] mag;
   logic              neg;

   always_comb begin
      tick = req_tdata[TICK_W-1:0];
      neg  = tick[TICK_W-1];
      mag  = neg ? (TICK_W'(0) - tick) : tick;
      q_entry.mag = mag[MAG_W-1:0];
      q_entry.oor = (mag > TICK_W'(TICK_LIMIT));
      q_entry.inv = !neg && (tick != '0);
      req_tready  = !q_full && !reset;
      q_push      = req_tvalid && req_tready;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/sptk_queue.sv -----
// Short queue between the classifying front and the arithmetic back.
`default_nettype none
module sptk_queue import sptk_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  tick_class_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           nempty,
   output tick_class_type head
);

   tick_class_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      nempty    = (count_ff != '0);
      head      = mem_ff[rd_ptr_ff];
      do_pop    = pop && nempty;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/sptk_mul_stage.sv -----
// One tick bit of the ratio product: (r * c) >> 128 over four register stages.
`default_nettype none
module sptk_mul_stage import sptk_pkg::*; #(
   parameter int unsigned BIT_IDX = 1
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   adv,
   input  mul_beat_type beat_i,
   output mul_beat_type beat_o
);

   localparam logic [127:0] CONST = bit_mult(5'(BIT_IDX));

   logic [31:0]  r_limb [5];
   logic [63:0]  pp_in [5][4];
   logic [63:0]  pp_ff [5][4];
   logic [191:0] row_in [4];
   logic [191:0] row_ff [4];
   logic [223:0] s01_in, s01_ff, s23_in, s23_ff;
   logic [287:0] full_prod;
   mul_beat_type a_ff, b_ff, c_ff, d_ff, d_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         r_limb[i] = beat_i.r[32*i +: 32];
      end
      r_limb[4] = {31'd0, beat_i.r[128]};
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_in[i][j] = 64'(r_limb[i]) * 64'(CONST[32*j +: 32]);
         end
      end
      for (int j = 0; j < 4; j++) begin
         row_in[j] = {pp_ff[4][j], pp_ff[2][j], pp_ff[0][j]}
                   + {32'd0, pp_ff[3][j], pp_ff[1][j], 32'd0};
      end
      s01_in    = {32'd0, row_ff[0]} + {row_ff[1], 32'd0};
      s23_in    = {32'd0, row_ff[2]} + {row_ff[3], 32'd0};
      full_prod = {64'd0, s01_ff} + {s23_ff, 64'd0};
      d_in      = c_ff;
      if (c_ff.mag[BIT_IDX]) begin
         d_in.r = full_prod[256:128];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
         b_ff.vld <= 1'b0;
         c_ff.vld <= 1'b0;
         d_ff.vld <= 1'b0;
      end else if (adv) begin
         a_ff <= beat_i;
         b_ff <= a_ff;
         c_ff <= b_ff;
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         s01_ff <= s01_in;
         s23_ff <= s23_in;
      end
   end

   assign beat_o = d_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sptk_div_stage.sv -----
// One quotient bit of the restoring division of all ones by the ratio.
`default_nettype none
module sptk_div_stage import sptk_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   adv,
   input  div_beat_type beat_i,
   output div_beat_type beat_o
);

   logic [RATIO_W:0]   sh;
   logic [RATIO_W+1:0] diff;
   logic               ge;
   div_beat_type       beat_in, beat_ff;

   always_comb begin
      sh           = {beat_i.rem, 1'b1};
      diff         = {1'b0, sh} - {2'b00, beat_i.r};
      ge           = !diff[RATIO_W+1];
      beat_in      = beat_i;
      beat_in.rem  = ge ? diff[RATIO_W-1:0] : sh[RATIO_W-1:0];
      beat_in.q    = {beat_i.q[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.vld <= 1'b0;
      end else if (adv) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sqrt_price_from_tick_top.sv -----
// Top level of the tick to Q64.96 square-root price engine.
// Usage:
//   The req channel carries one signed 21-bit tick per beat in req_tdata[20:0].
//   The rsp channel returns one beat per tick: the 160-bit Q64.96 price in
//   rsp_tdata (low, mid and high words from bit 0 up) and the range error flag
//   in rsp_tuser. Ticks beyond the limit return a zero price with the flag set.
//   An accepted tick is written into the queue at the accepting edge, then
//   goes from the queue head through four register stages per tick bit in
//   the nineteen product stages, one per quotient bit in the 256-stage
//   divider and the output register. Throughput is one tick per cycle
//   unless rsp_tready stalls it; every stage is a separate register.
//   When rsp_tready is low with a result waiting, the whole back pipeline
//   holds, and the four-entry input queue keeps taking ticks until full.
//   Reset clears all valid bits and the queue; nothing else is kept.
`default_nettype none
module sqrt_price_from_tick_top import sptk_pkg::*; #(
   parameter int unsigned TICK_LIMIT = 887272
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // [20:0] tick
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,   // [63:0] low, [127:64] mid, [159:128] high word
   output logic              rsp_tuser    // [0] range error flag
);

   localparam int unsigned NUM_MUL = MAG_W - 1;

   logic            q_full, q_push, q_nempty, adv;
   tick_class_type  q_entry, q_head;
   mul_beat_type    mul_chain [NUM_MUL+1];
   div_beat_type    div_chain [QUOT_W+1];
   logic [QUOT_W-1:0]  val;
   logic [PRICE_W-1:0] price_in, price_ff;
   logic               oor_ff, vld_ff;

   assign adv = !vld_ff || rsp_tready;

   sptk_front #(.TICK_LIMIT(TICK_LIMIT)) u_front (
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   sptk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (adv),
      .full      (q_full),
      .nempty    (q_nempty),
      .head      (q_head)
   );

   always_comb begin
      mul_chain[0].vld = q_nempty;
      mul_chain[0].inv = q_head.inv;
      mul_chain[0].oor = q_head.oor;
      mul_chain[0].mag = q_head.mag;
      mul_chain[0].r   = q_head.mag[0] ? {1'b0, bit_mult(5'd0)}
                                       : {1'b1, 128'd0};
   end

   for (genvar k = 1; k <= NUM_MUL; k++) begin : g_mul
      sptk_mul_stage #(.BIT_IDX(k)) u_mul (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .beat_i(mul_chain[k-1]),
         .beat_o(mul_chain[k])
      );
   end

   always_comb begin
      div_chain[0].vld = mul_chain[NUM_MUL].vld;
      div_chain[0].inv = mul_chain[NUM_MUL].inv;
      div_chain[0].oor = mul_chain[NUM_MUL].oor;
      div_chain[0].r   = mul_chain[NUM_MUL].r;
      div_chain[0].rem = '0;
      div_chain[0].q   = '0;
   end

   for (genvar b = 1; b <= QUOT_W; b++) begin : g_div
      sptk_div_stage u_div (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .beat_i(div_chain[b-1]),
         .beat_o(div_chain[b])
      );
   end

   always_comb begin
      val = div_chain[QUOT_W].inv ? div_chain[QUOT_W].q
                                  : {127'd0, div_chain[QUOT_W].r};
      price_in = val[191:32] + PRICE_W'(val[31:0] != '0);
      if (div_chain[QUOT_W].oor) begin
         price_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= div_chain[QUOT_W].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         price_ff <= price_in;
         oor_ff   <= div_chain[QUOT_W].oor;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = price_ff;
   assign rsp_tuser  = oor_ff;

endmodule
`default_nettype wire
